### rtl/vmie_pkg.sv
package vmie_pkg;

	localparam int STACK_DEPTH_DEF = 16;

	localparam int PC_W   = 12;
	localparam int REG_W  = 8;
	localparam int RIDX_W = 4;
	localparam int NREGS  = 16;

	localparam logic [RIDX_W-1:0] FLAG_REG = 4'hF;
	localparam logic [PC_W-1:0]   RESET_PC = 12'h200;

	// operation groups (top nibble)
	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SE   = 4'h3;
	localparam logic [3:0] GRP_SNE  = 4'h4;
	localparam logic [3:0] GRP_SEV  = 4'h5;
	localparam logic [3:0] GRP_LD   = 4'h6;
	localparam logic [3:0] GRP_ADD  = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SNEV = 4'h9;
	localparam logic [3:0] GRP_LDI  = 4'hA;
	localparam logic [3:0] GRP_JPV0 = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;

	// system words
	localparam logic [15:0] INS_CLS = 16'h00E0;
	localparam logic [15:0] INS_RET = 16'h00EE;

	// ALU group low nibble
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	typedef struct packed {
		logic [15:0]       ins;
		logic [REG_W-1:0]  rnd;
		logic [REG_W-1:0]  vx;
		logic [REG_W-1:0]  vy;
		logic [REG_W-1:0]  v0;
		logic [REG_W-1:0]  vf;
		logic [PC_W-1:0]   pc;
		logic [PC_W-1:0]   index;
		logic [PC_W-1:0]   top;
		logic              stack_full;
		logic              stack_empty;
	} exec_in_t;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic [PC_W-1:0]   index;
		logic              dw;
		logic [RIDX_W-1:0] dest_reg;
		logic [REG_W-1:0]  dest_value;
		logic              fw;
		logic [REG_W-1:0]  flag_value;
		logic              cls;
		logic              uns;
		logic              sf;
		logic              push;
		logic              pop;
		logic [PC_W-1:0]   push_value;
	} exec_out_t;

endpackage

### rtl/vmie_exec.sv
module vmie_exec (
	input  vmie_pkg::exec_in_t  ei,
	output vmie_pkg::exec_out_t eo
);
	import vmie_pkg::*;

	logic [3:0]        grp;
	logic [RIDX_W-1:0] x;
	logic [RIDX_W-1:0] y;
	logic [3:0]        low;
	logic [REG_W-1:0]  kk;
	logic [PC_W-1:0]   nnn;
	logic [PC_W-1:0]   pc2;
	logic [PC_W-1:0]   pc4;
	logic [REG_W:0]    sum;
	logic [REG_W-1:0]  flag_new;
	logic [REG_W-1:0]  vxe;
	logic [REG_W-1:0]  vye;
	logic [REG_W-1:0]  res;

	assign grp = ei.ins[15:12];
	assign x   = ei.ins[11:8];
	assign y   = ei.ins[7:4];
	assign low = ei.ins[3:0];
	assign kk  = ei.ins[7:0];
	assign nnn = ei.ins[11:0];
	assign pc2 = ei.pc + 12'd2;
	assign pc4 = pc2 + 12'd2;
	assign sum = {1'b0, ei.vx} + {1'b0, ei.vy};

	// flag is computed from the operands as read, before any update
	always_comb begin
		case (low)
			ALU_ADD: flag_new = {7'd0, sum[REG_W]};
			ALU_SUB: flag_new = {7'd0, ei.vx > ei.vy};
			ALU_SHR: flag_new = {7'd0, ei.vx[0]};
			ALU_SBN: flag_new = {7'd0, ei.vy > ei.vx};
			ALU_SHL: flag_new = {7'd0, ei.vx[REG_W-1]};
			default: flag_new = ei.vf;
		endcase
	end

	// operands as seen after the flag write
	assign vxe = (x == FLAG_REG) ? flag_new : ei.vx;
	assign vye = (y == FLAG_REG) ? flag_new : ei.vy;

	always_comb begin
		eo            = '0;
		eo.next_pc    = pc2;
		eo.index      = ei.index;
		eo.push_value = pc2;
		res           = '0;
		case (grp)
			GRP_SYS: begin
				if (ei.ins == INS_CLS) begin
					eo.cls = 1'b1;
				end else if (ei.ins == INS_RET) begin
					if (ei.stack_empty) begin
						eo.sf = 1'b1;
					end else begin
						eo.pop     = 1'b1;
						eo.next_pc = ei.top;
					end
				end else begin
					eo.uns = 1'b1;
				end
			end
			GRP_JP: eo.next_pc = nnn;
			GRP_CALL: begin
				if (ei.stack_full) begin
					eo.sf = 1'b1;
				end else begin
					eo.push    = 1'b1;
					eo.next_pc = nnn;
				end
			end
			GRP_SE: if (ei.vx == kk) eo.next_pc = pc4;
			GRP_SNE: if (ei.vx != kk) eo.next_pc = pc4;
			GRP_SEV: begin
				if (low != 4'd0) eo.uns = 1'b1;
				else if (ei.vx == ei.vy) eo.next_pc = pc4;
			end
			GRP_SNEV: begin
				if (low != 4'd0) eo.uns = 1'b1;
				else if (ei.vx != ei.vy) eo.next_pc = pc4;
			end
			GRP_LD: begin
				eo.dw = 1'b1;
				res   = kk;
			end
			GRP_ADD: begin
				eo.dw = 1'b1;
				res   = ei.vx + kk;
			end
			GRP_ALU: begin
				eo.dw = 1'b1;
				case (low)
					ALU_MOV: res = ei.vy;
					ALU_OR:  res = ei.vx | ei.vy;
					ALU_AND: res = ei.vx & ei.vy;
					ALU_XOR: res = ei.vx ^ ei.vy;
					ALU_ADD: begin
						eo.fw = 1'b1;
						res   = sum[REG_W-1:0];
					end
					ALU_SUB: begin
						eo.fw = 1'b1;
						res   = vxe - vye;
					end
					ALU_SHR: begin
						eo.fw = 1'b1;
						res   = {1'b0, vxe[REG_W-1:1]};
					end
					ALU_SBN: begin
						eo.fw = 1'b1;
						res   = vye - vxe;
					end
					ALU_SHL: begin
						eo.fw = 1'b1;
						res   = {vxe[REG_W-2:0], 1'b0};
					end
					default: begin
						eo.dw  = 1'b0;
						eo.uns = 1'b1;
					end
				endcase
			end
			GRP_LDI: eo.index = nnn;
			GRP_JPV0: eo.next_pc = {4'd0, ei.v0} + nnn;
			GRP_RND: begin
				eo.dw = 1'b1;
				res   = ei.rnd & kk;
			end
			default: eo.uns = 1'b1;
		endcase

		eo.dest_reg   = eo.dw ? x : '0;
		eo.dest_value = eo.dw ? res : '0;
		// a result aimed at VF overrides the flag
		if (eo.dw && (x == FLAG_REG)) eo.flag_value = res;
		else if (eo.fw) eo.flag_value = flag_new;
		else eo.flag_value = ei.vf;
	end

endmodule

### rtl/vm_instruction_execute.sv
// Instruction execute core for a small 8-bit virtual machine.
// Request channel: instruction (16 bit) and random_byte (8 bit), taken when
// instr_valid and instr_ready are both high at a rising edge of clk.
// Result channel: next_pc, index_value, dest_write/dest_reg/dest_value,
// flag_write/flag_value, clear_display, unsupported and stack_fault, offered
// with result_valid and taken when result_ready is high.
// A request is captured into the execute stage together with its
// register-file reads, and its result is then registered in the result
// register. Throughput is one request per cycle while the receiver takes
// each result; the register-file write of one request is forwarded to
// the operand reads of the request taken at the same edge.
// When the receiver stalls, the result register holds, the execute stage
// holds one more request, and instr_ready drops once both are occupied.
// Start address: a write with cfg_we loads the program counter at once;
// write it only while the core is idle.
// Reset (arst_n low, asynchronous): registers V0..VF read as zero, the
// counter loads 0x200, index and stack depth clear, both stages empty.
// Return stack entries hold no defined value until a call writes them.
module vm_instruction_execute #(
	parameter int STACK_DEPTH = vmie_pkg::STACK_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [vmie_pkg::PC_W-1:0] cfg_wdata,
	input  logic                      instr_valid,
	output logic                      instr_ready,
	input  logic [15:0]               instruction,
	input  logic [7:0]                random_byte,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [11:0]               next_pc,
	output logic [11:0]               index_value,
	output logic                      dest_write,
	output logic [3:0]                dest_reg,
	output logic [7:0]                dest_value,
	output logic                      flag_write,
	output logic [7:0]                flag_value,
	output logic                      clear_display,
	output logic                      unsupported,
	output logic                      stack_fault
);
	import vmie_pkg::*;

	localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

	// architectural state
	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   index_q;
	logic [REG_W-1:0]  v0_q;
	logic [REG_W-1:0]  vf_q;
	logic [NREGS-1:0]  rvalid_q;
	logic [REG_W-1:0]  regs_mem [NREGS];
	logic [PC_W-1:0]   stk_mem [STACK_DEPTH];
	logic [SCNT_W-1:0] depth_q;
	logic [PC_W-1:0]   top_q;

	// execute stage
	logic              valid_s1;
	logic [15:0]       ins_s1;
	logic [REG_W-1:0]  rnd_s1;
	logic [REG_W-1:0]  vx_s1;
	logic [REG_W-1:0]  vy_s1;

	logic              accept;
	logic              advance;
	exec_in_t          ei;
	exec_out_t         eo;
	logic [RIDX_W-1:0] x_s1;
	logic              rf_we;
	logic [REG_W-1:0]  vf_next;
	logic [RIDX_W-1:0] rx;
	logic [RIDX_W-1:0] ry;
	logic [SCNT_W-1:0] depth_next;
	logic [SCNT_W-1:0] top_cnt;

	// move the execute stage on when the result register is free or draining
	assign advance     = valid_s1 && (!result_valid || result_ready);
	assign instr_ready = !valid_s1 || advance;
	assign accept      = instr_valid && instr_ready;

	assign x_s1 = ins_s1[11:8];
	assign rx   = instruction[11:8];
	assign ry   = instruction[7:4];

	assign ei.ins         = ins_s1;
	assign ei.rnd         = rnd_s1;
	assign ei.vx          = vx_s1;
	assign ei.vy          = vy_s1;
	assign ei.v0          = v0_q;
	assign ei.vf          = vf_q;
	assign ei.pc          = pc_q;
	assign ei.index       = index_q;
	assign ei.top         = top_q;
	assign ei.stack_full  = (depth_q == SCNT_W'(STACK_DEPTH));
	assign ei.stack_empty = (depth_q == '0);

	vmie_exec u_exec (
		.ei (ei),
		.eo (eo)
	);

	// VF lives in its own register; the array takes V0..VE
	assign rf_we   = advance && eo.dw && (x_s1 != FLAG_REG);
	assign vf_next = advance ? eo.flag_value : vf_q;

	always_comb begin
		depth_next = depth_q;
		if (advance && eo.push) depth_next = depth_q + SCNT_W'(1);
		else if (advance && eo.pop) depth_next = depth_q - SCNT_W'(1);
	end
	assign top_cnt = depth_next - SCNT_W'(1);

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
			pc_q         <= RESET_PC;
			index_q      <= '0;
			v0_q         <= '0;
			vf_q         <= '0;
			rvalid_q     <= '0;
			depth_q      <= '0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;

			if (advance) result_valid <= 1'b1;
			else if (result_ready) result_valid <= 1'b0;

			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end else if (advance) begin
				pc_q <= eo.next_pc;
			end

			if (advance) begin
				index_q <= eo.index;
				vf_q    <= eo.flag_value;
				depth_q <= depth_next;
				if (eo.dw && (x_s1 == RIDX_W'(0))) v0_q <= eo.dest_value;
			end
			if (rf_we) rvalid_q[x_s1] <= 1'b1;
		end
	end

	// register file write
	always_ff @(posedge clk) begin
		if (rf_we) regs_mem[x_s1] <= eo.dest_value;
	end

	// capture request and operands, forwarding the write committing now
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= instruction;
			rnd_s1 <= random_byte;
			if (rx == FLAG_REG) vx_s1 <= vf_next;
			else if (rf_we && (x_s1 == rx)) vx_s1 <= eo.dest_value;
			else if (rvalid_q[rx]) vx_s1 <= regs_mem[rx];
			else vx_s1 <= '0;
			if (ry == FLAG_REG) vy_s1 <= vf_next;
			else if (rf_we && (x_s1 == ry)) vy_s1 <= eo.dest_value;
			else if (rvalid_q[ry]) vy_s1 <= regs_mem[ry];
			else vy_s1 <= '0;
		end
	end

	// return stack: write on call, keep the top entry registered
	always_ff @(posedge clk) begin
		if (advance && eo.push) begin
			stk_mem[depth_q[SIDX_W-1:0]] <= eo.push_value;
			top_q                        <= eo.push_value;
		end else if (advance && eo.pop && (depth_next != '0)) begin
			top_q <= stk_mem[top_cnt[SIDX_W-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance) begin
			next_pc       <= eo.next_pc;
			index_value   <= eo.index;
			dest_write    <= eo.dw;
			dest_reg      <= eo.dest_reg;
			dest_value    <= eo.dest_value;
			flag_write    <= eo.fw;
			flag_value    <= eo.flag_value;
			clear_display <= eo.cls;
			unsupported   <= eo.uns;
			stack_fault   <= eo.sf;
		end
	end

endmodule

### rtl/vmie_checker.sv
module vmie_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [11:0] next_pc,
	input logic       dest_write,
	input logic [3:0] dest_reg,
	input logic [7:0] dest_value,
	input logic       flag_write,
	input logic       clear_display,
	input logic       unsupported,
	input logic       stack_fault
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(next_pc))
		else $error("stalled result dropped or changed");

	// unsupported requests change no register and touch no stack
	a_uns: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && unsupported |-> !dest_write && !flag_write && !stack_fault)
		else $error("unsupported request wrote state");

	// no register write reports zeros
	a_dest: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !dest_write |-> dest_reg == 4'd0 && dest_value == 8'd0)
		else $error("dest fields set without a write");

	// a flag write comes only from an ALU op that also writes its destination
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && flag_write |-> dest_write && !clear_display && !stack_fault)
		else $error("flag write without ALU result");

endmodule

bind vm_instruction_execute vmie_checker u_vmie_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.next_pc       (next_pc),
	.dest_write    (dest_write),
	.dest_reg      (dest_reg),
	.dest_value    (dest_value),
	.flag_write    (flag_write),
	.clear_display (clear_display),
	.unsupported   (unsupported),
	.stack_fault   (stack_fault)
);
